// ----- design/asbe_pkg.sv -----
// ----------------------------------------------------------------------------
// asbe_pkg
// types and codes shared by the array stack and bag engine: request and
// response beats, operation and error codes, controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package asbe_pkg;

   typedef enum logic [2:0] {
      OP_PUSH         = 3'd0,
      OP_POP          = 3'd1,
      OP_GET          = 3'd2,
      OP_PUT          = 3'd3,
      OP_SWAP         = 3'd4,
      OP_REMOVE_AT    = 3'd5,
      OP_CONTAINS     = 3'd6,
      OP_REMOVE_VALUE = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [9:0]         position_a;
      logic [9:0]         position_b;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               found;
      logic [1:0]         error_code;
      logic [10:0]        element_count;
      logic               is_empty;
      logic signed [31:0] top_value;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GET_WAIT,
      ST_SWAP_RB,
      ST_SWAP_WA,
      ST_SWAP_WB,
      ST_SCAN,
      ST_SHIFT,
      ST_TOP,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_PA,
      RD_PB,
      RD_SRC,
      RD_TOP
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_PUSH,
      WR_PUT,
      WR_SWAP_A,
      WR_SWAP_B,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_FROM_PA,
      PTR_FROM_ZERO,
      PTR_FROM_MATCH,
      PTR_STEP
   } ptr_op_type;

   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      ptr_op_type ptr_op;
      logic       cap_read;
      logic       cap_hold;
      logic       set_err;
      logic       set_found;
   } cmd_type;

   typedef struct packed {
      op_type  kind;
      err_type code;
      logic    more;
      logic    pend;
      logic    match;
   } status_type;

endpackage

// ----- design/array_stack_bag_engine_unit.sv -----
// ----------------------------------------------------------------------------
// array_stack_bag_engine_unit
// bounded word stack with indexed access, swap, remove-at with shift-down,
// linear search and remove of the first matching entry
//
//   channel   ports                      beat taken when
//   request   start, busy, req_payload   start high, busy low
//   response  rsp_strobe, rsp_payload    rsp_strobe high (one cycle)
//
// push, pop and put pass decode, top and done; get adds a read wait; swap
// reads both entries and writes them back in turn; remove_at and search walk
// the memory one entry a cycle through its single read port, and remove of a
// value searches first and then shifts down
// one operation in flight; busy stays high through the response beat
// reset clears the controller state, the count and the walk pending flag only; no stall on the response side
// ----------------------------------------------------------------------------
module array_stack_bag_engine_unit #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  asbe_pkg::req_type  req_payload,
   output logic               busy,
   output logic               rsp_strobe,
   output asbe_pkg::rsp_type  rsp_payload
);

   asbe_pkg::cmd_type    cmd;
   asbe_pkg::status_type status;

   asbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   asbe_dpath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- design/asbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// asbe_ctrl
// controller state machine: decodes the held request, sequences memory
// reads and writes, the search and shift-down walks and the response beat
// ----------------------------------------------------------------------------
module asbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  asbe_pkg::status_type   status,
   output asbe_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   asbe_pkg::ctrl_state_type state_ff;
   asbe_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asbe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         asbe_pkg::ST_IDLE: begin
            if (start) begin
               state_in = asbe_pkg::ST_DECODE;
            end
         end
         asbe_pkg::ST_DECODE: begin
            if (status.code != asbe_pkg::ERR_OK) begin
               state_in = asbe_pkg::ST_TOP;
            end else begin
               unique case (status.kind)
                  asbe_pkg::OP_GET:          state_in = asbe_pkg::ST_GET_WAIT;
                  asbe_pkg::OP_SWAP:         state_in = asbe_pkg::ST_SWAP_RB;
                  asbe_pkg::OP_REMOVE_AT:    state_in = asbe_pkg::ST_SHIFT;
                  asbe_pkg::OP_CONTAINS:     state_in = asbe_pkg::ST_SCAN;
                  asbe_pkg::OP_REMOVE_VALUE: state_in = asbe_pkg::ST_SCAN;
                  default:                   state_in = asbe_pkg::ST_TOP;
               endcase
            end
         end
         asbe_pkg::ST_GET_WAIT: state_in = asbe_pkg::ST_TOP;
         asbe_pkg::ST_SWAP_RB:  state_in = asbe_pkg::ST_SWAP_WA;
         asbe_pkg::ST_SWAP_WA:  state_in = asbe_pkg::ST_SWAP_WB;
         asbe_pkg::ST_SWAP_WB:  state_in = asbe_pkg::ST_TOP;
         asbe_pkg::ST_SCAN: begin
            priority if (status.match) begin
               if (status.kind == asbe_pkg::OP_REMOVE_VALUE) begin
                  state_in = asbe_pkg::ST_SHIFT;
               end else begin
                  state_in = asbe_pkg::ST_TOP;
               end
            end else if (!status.pend && !status.more) begin
               state_in = asbe_pkg::ST_TOP;
            end
         end
         asbe_pkg::ST_SHIFT: begin
            if (!status.pend && !status.more) begin
               state_in = asbe_pkg::ST_TOP;
            end
         end
         asbe_pkg::ST_TOP:  state_in = asbe_pkg::ST_DONE;
         asbe_pkg::ST_DONE: state_in = asbe_pkg::ST_IDLE;
         default:           state_in = asbe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load      = 1'b0;
      cmd.rd_sel    = asbe_pkg::RD_NONE;
      cmd.wr_sel    = asbe_pkg::WR_NONE;
      cmd.cnt_op    = asbe_pkg::CNT_HOLD;
      cmd.ptr_op    = asbe_pkg::PTR_HOLD;
      cmd.cap_read  = 1'b0;
      cmd.cap_hold  = 1'b0;
      cmd.set_err   = 1'b0;
      cmd.set_found = 1'b0;
      busy          = (state_ff != asbe_pkg::ST_IDLE);
      rsp_strobe    = (state_ff == asbe_pkg::ST_DONE);
      unique case (state_ff)
         asbe_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         asbe_pkg::ST_DECODE: begin
            cmd.set_err = 1'b1;
            if (status.code == asbe_pkg::ERR_OK) begin
               unique case (status.kind)
                  asbe_pkg::OP_PUSH: begin
                     cmd.wr_sel = asbe_pkg::WR_PUSH;
                     cmd.cnt_op = asbe_pkg::CNT_INC;
                  end
                  asbe_pkg::OP_POP: begin
                     cmd.cnt_op = asbe_pkg::CNT_DEC;
                  end
                  asbe_pkg::OP_GET: begin
                     cmd.rd_sel = asbe_pkg::RD_PA;
                  end
                  asbe_pkg::OP_PUT: begin
                     cmd.wr_sel = asbe_pkg::WR_PUT;
                  end
                  asbe_pkg::OP_SWAP: begin
                     cmd.rd_sel = asbe_pkg::RD_PA;
                  end
                  asbe_pkg::OP_REMOVE_AT: begin
                     cmd.ptr_op = asbe_pkg::PTR_FROM_PA;
                  end
                  default: begin
                     cmd.ptr_op = asbe_pkg::PTR_FROM_ZERO;
                  end
               endcase
            end
         end
         asbe_pkg::ST_GET_WAIT: begin
            cmd.cap_read = 1'b1;
         end
         asbe_pkg::ST_SWAP_RB: begin
            cmd.rd_sel   = asbe_pkg::RD_PB;
            cmd.cap_hold = 1'b1;
         end
         asbe_pkg::ST_SWAP_WA: begin
            cmd.wr_sel = asbe_pkg::WR_SWAP_A;
         end
         asbe_pkg::ST_SWAP_WB: begin
            cmd.wr_sel = asbe_pkg::WR_SWAP_B;
         end
         asbe_pkg::ST_SCAN: begin
            if (status.match) begin
               cmd.set_found = 1'b1;
               if (status.kind == asbe_pkg::OP_REMOVE_VALUE) begin
                  cmd.ptr_op = asbe_pkg::PTR_FROM_MATCH;
               end
            end else begin
               cmd.rd_sel = asbe_pkg::RD_SRC;
               cmd.ptr_op = asbe_pkg::PTR_STEP;
            end
         end
         asbe_pkg::ST_SHIFT: begin
            cmd.rd_sel = asbe_pkg::RD_SRC;
            cmd.wr_sel = asbe_pkg::WR_SHIFT;
            cmd.ptr_op = asbe_pkg::PTR_STEP;
            if (!status.pend && !status.more) begin
               cmd.cnt_op = asbe_pkg::CNT_DEC;
            end
         end
         asbe_pkg::ST_TOP: begin
            cmd.rd_sel = asbe_pkg::RD_TOP;
         end
         asbe_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- design/asbe_dpath.sv -----
// ----------------------------------------------------------------------------
// asbe_dpath
// datapath: request register, entry memory with one write and one
// registered read port, entry count, walk pointers, match compare and
// response fields
// ----------------------------------------------------------------------------
module asbe_dpath #(
   parameter int DEPTH     = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  asbe_pkg::cmd_type     cmd,
   input  asbe_pkg::req_type     req_payload,
   output asbe_pkg::status_type  status,
   output asbe_pkg::rsp_type     rsp_payload
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > 10) ? CW : 10;

   asbe_pkg::req_type     req_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [CW-1:0]         src_ff;
   logic [CW-1:0]         src_in;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         idx_in;
   logic                  pend_ff;
   logic                  pend_in;
   logic [WORD_BITS-1:0]  mem [DEPTH];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic [WORD_BITS-1:0]  hold_ff;
   logic [WORD_BITS-1:0]  read_ff;
   logic                  found_ff;
   asbe_pkg::err_type     err_ff;

   asbe_pkg::op_type      kind;
   asbe_pkg::err_type     code;
   logic [WORD_BITS-1:0]  val_w;
   logic [CMPW-1:0]       pa_ext;
   logic [CMPW-1:0]       pb_ext;
   logic [CMPW-1:0]       cnt_ext;
   logic                  pa_bad;
   logic                  pb_bad;
   logic                  cnt_zero;
   logic                  cnt_full;
   logic                  more;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   assign kind     = asbe_pkg::op_type'(req_ff.kind);
   assign val_w    = WORD_BITS'($unsigned(req_ff.value));
   assign pa_ext   = CMPW'(req_ff.position_a);
   assign pb_ext   = CMPW'(req_ff.position_b);
   assign cnt_ext  = CMPW'(count_ff);
   assign pa_bad   = (pa_ext >= cnt_ext);
   assign pb_bad   = (pb_ext >= cnt_ext);
   assign cnt_zero = (count_ff == '0);
   assign cnt_full = (count_ff == CW'(DEPTH));
   assign more     = (src_ff < count_ff);

   // precondition check for the held request
   always_comb begin
      code = asbe_pkg::ERR_OK;
      unique case (kind)
         asbe_pkg::OP_PUSH: begin
            if (cnt_full) code = asbe_pkg::ERR_FULL;
         end
         asbe_pkg::OP_POP, asbe_pkg::OP_CONTAINS, asbe_pkg::OP_REMOVE_VALUE: begin
            if (cnt_zero) code = asbe_pkg::ERR_RANGE;
         end
         asbe_pkg::OP_SWAP: begin
            if (pa_bad || pb_bad) code = asbe_pkg::ERR_RANGE;
         end
         default: begin
            if (pa_bad) code = asbe_pkg::ERR_RANGE;
         end
      endcase
   end

   assign status.kind  = kind;
   assign status.code  = code;
   assign status.more  = more;
   assign status.pend  = pend_ff;
   assign status.match = pend_ff && (rd_data_ff == val_w);

   // read port select
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (cmd.rd_sel)
         asbe_pkg::RD_PA: begin
            rd_en   = 1'b1;
            rd_addr = AW'(req_ff.position_a);
         end
         asbe_pkg::RD_PB: begin
            rd_en   = 1'b1;
            rd_addr = AW'(req_ff.position_b);
         end
         asbe_pkg::RD_SRC: begin
            rd_en   = more;
            rd_addr = AW'(src_ff);
         end
         asbe_pkg::RD_TOP: begin
            rd_en   = 1'b1;
            rd_addr = AW'(count_ff - CW'(1));
         end
         default: begin
         end
      endcase
   end

   // write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = val_w;
      unique case (cmd.wr_sel)
         asbe_pkg::WR_PUSH: begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_ff);
         end
         asbe_pkg::WR_PUT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(req_ff.position_a);
         end
         asbe_pkg::WR_SWAP_A: begin
            wr_en   = 1'b1;
            wr_addr = AW'(req_ff.position_a);
            wr_data = rd_data_ff;
         end
         asbe_pkg::WR_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = AW'(req_ff.position_b);
            wr_data = hold_ff;
         end
         asbe_pkg::WR_SHIFT: begin
            wr_en   = pend_ff;
            wr_addr = AW'(idx_ff - CW'(1));
            wr_data = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // walk pointers: src is the next entry to read, idx the entry in flight
   always_comb begin
      src_in  = src_ff;
      idx_in  = idx_ff;
      pend_in = pend_ff;
      unique case (cmd.ptr_op)
         asbe_pkg::PTR_FROM_PA: begin
            src_in  = CW'(pa_ext + CMPW'(1));
            pend_in = 1'b0;
         end
         asbe_pkg::PTR_FROM_ZERO: begin
            src_in  = '0;
            pend_in = 1'b0;
         end
         asbe_pkg::PTR_FROM_MATCH: begin
            src_in  = idx_ff + CW'(1);
            pend_in = 1'b0;
         end
         asbe_pkg::PTR_STEP: begin
            pend_in = more;
            if (more) begin
               idx_in = src_ff;
               src_in = src_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         asbe_pkg::CNT_INC: count_in = count_ff + CW'(1);
         asbe_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:           count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      idx_ff <= idx_in;
      if (cmd.load) begin
         req_ff   <= req_payload;
         read_ff  <= '0;
         found_ff <= 1'b0;
         err_ff   <= asbe_pkg::ERR_OK;
      end else begin
         if (cmd.cap_read) read_ff <= rd_data_ff;
         if (cmd.set_found) found_ff <= 1'b1;
         if (cmd.set_err) err_ff <= code;
      end
      if (cmd.cap_hold) begin
         hold_ff <= rd_data_ff;
      end
   end

   assign rsp_payload.read_value    = 32'(read_ff);
   assign rsp_payload.found         = found_ff;
   assign rsp_payload.error_code    = err_ff;
   assign rsp_payload.element_count = 11'(count_ff);
   assign rsp_payload.is_empty      = cnt_zero;
   assign rsp_payload.top_value     = cnt_zero ? '0 : 32'(rd_data_ff);

endmodule
